// ===== rtl/core/ptts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task tick scheduler package
// Shared widths, operation and result codes, and the types that pass between
// the control logic and the row of slot cells.
// ----------------------------------------------------------------------------
package ptts_pkg;

   // Field widths of the request and response channels.
   localparam int OP_W      = 3;
   localparam int SLOT_W    = 3;
   localparam int HANDLER_W = 8;
   localparam int TIME_W    = 16;
   localparam int KIND_W    = 2;

   // Default number of task slots in the table.
   localparam int SLOT_COUNT_DEF = 8;

   // Request operations.
   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 3'd0,
      OP_CREATE  = 3'd1,
      OP_SUSPEND = 3'd2,
      OP_RESUME  = 3'd3,
      OP_DELETE  = 3'd4
   } op_type;

   // Response kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_STATUS    = 2'd0,
      KIND_FIRED     = 2'd1,
      KIND_TICK_NONE = 2'd2
   } kind_type;

   // Operation status codes.
   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_NO_HANDLER = 1'b1;

   // Control states of the scheduler.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Operation broadcast to every cell; only the addressed cell acts on it.
   typedef struct packed {
      logic                 valid;
      op_type               op;
      logic [SLOT_W-1:0]    slot;
      logic [HANDLER_W-1:0] handler;
      logic [TIME_W-1:0]    period;
      logic [TIME_W-1:0]    first_delay;
   } cmd_type;

   // Firing report of one cell; all zero unless the cell fires.
   typedef struct packed {
      logic                 fire;
      logic [SLOT_W-1:0]    slot;
      logic [HANDLER_W-1:0] handler;
   } fire_type;

endpackage

// ===== rtl/core/ptts_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task tick scheduler channel interfaces
// Valid/ready channels for scheduler requests and for scheduler responses.
// ----------------------------------------------------------------------------

// Request channel: one operation or tick per request.
interface ptts_req_if;
   logic                           valid;
   logic                           ready;
   logic [ptts_pkg::OP_W-1:0]      op;
   logic [ptts_pkg::SLOT_W-1:0]    slot;
   logic [ptts_pkg::HANDLER_W-1:0] handler;
   logic [ptts_pkg::TIME_W-1:0]    period;
   logic [ptts_pkg::TIME_W-1:0]    first_delay;

   modport source (output valid, op, slot, handler, period, first_delay, input ready);
   modport sink (input valid, op, slot, handler, period, first_delay, output ready);
endinterface

// Response channel: status or fired-task results.
interface ptts_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ptts_pkg::KIND_W-1:0]    kind;
   logic                           status;
   logic [ptts_pkg::SLOT_W-1:0]    fired_slot;
   logic [ptts_pkg::HANDLER_W-1:0] fired_handler;
   logic                           last;

   modport source (output valid, kind, status, fired_slot, fired_handler, last, input ready);
   modport sink (input valid, kind, status, fired_slot, fired_handler, last, output ready);
endinterface

// ===== rtl/core/ptts_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task tick scheduler slot cell
// Holds one task slot and passes the tick scan token to its right neighbor.
// ----------------------------------------------------------------------------
module ptts_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  ptts_pkg::cmd_type  cmd,
   input  logic               token_in,
   input  logic               step,
   output logic               token_out,
   output ptts_pkg::fire_type fire_out
);

   logic [ptts_pkg::HANDLER_W-1:0] handler_ff, handler_in;
   logic [ptts_pkg::TIME_W-1:0]    period_ff, period_in;
   logic [ptts_pkg::TIME_W-1:0]    countdown_ff, countdown_in;
   logic                           running_ff, running_in;
   logic                           token_ff, token_in_nx;
   logic                           addressed;
   logic                           visit;
   logic                           zero_count;

   assign addressed  = cmd.valid && (int'(cmd.slot) == CELL_INDEX);
   assign visit      = token_ff && step;
   assign zero_count = (countdown_ff == '0);

   // The scan token moves one cell to the right on every step.
   assign token_in_nx = step ? token_in : token_ff;
   assign token_out   = token_ff;

   // Report a firing while this cell holds the token.
   always_comb begin
      fire_out = '0;
      if (token_ff && running_ff && zero_count && (handler_ff != '0)) begin
         fire_out.fire    = 1'b1;
         fire_out.slot    = ptts_pkg::SLOT_W'(CELL_INDEX);
         fire_out.handler = handler_ff;
      end
   end

   // Slot update from an addressed operation or from the tick visit.
   always_comb begin
      handler_in   = handler_ff;
      period_in    = period_ff;
      countdown_in = countdown_ff;
      running_in   = running_ff;
      if (addressed) begin
         case (cmd.op)
            ptts_pkg::OP_CREATE: begin
               if ((cmd.handler != '0) && (handler_ff == '0)) begin
                  handler_in   = cmd.handler;
                  period_in    = cmd.period;
                  countdown_in = cmd.first_delay;
                  running_in   = 1'b1;
               end
            end
            ptts_pkg::OP_SUSPEND: running_in = 1'b0;
            ptts_pkg::OP_RESUME:  running_in = 1'b1;
            ptts_pkg::OP_DELETE:  handler_in = '0;
            default: ;
         endcase
      end else if (visit && running_ff) begin
         countdown_in = zero_count ? (period_ff - 1'b1) : (countdown_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         handler_ff   <= '0;
         period_ff    <= '0;
         countdown_ff <= '0;
         running_ff   <= 1'b0;
         token_ff     <= 1'b0;
      end else begin
         handler_ff   <= handler_in;
         period_ff    <= period_in;
         countdown_ff <= countdown_in;
         running_ff   <= running_in;
         token_ff     <= token_in_nx;
      end
   end

endmodule

// ===== rtl/core/periodic_task_tick_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task tick scheduler
// Task table held in a row of slot cells; a tick walks a token down the row
// and reports the firing tasks in slot order.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_if    in         op, slot, handler, period, first_delay
//  rsp_if    out        kind, status, fired_slot, fired_handler, last
//
// Create, suspend, resume and delete each answer with one status. In a tick the
// scan token visits one cell per cycle while the scan is not paused, then the
// final response is issued. A fired task is held back by one firing so that the
// final one carries last; the scan pauses while the response register is full
// and a held response must go out. Reset is synchronous and empties every slot.
// A new request is taken only when the scheduler is idle.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
   parameter int SLOT_COUNT = ptts_pkg::SLOT_COUNT_DEF
) (
   input logic       clock,
   input logic       reset,
   ptts_req_if.sink  req_if,
   ptts_rsp_if.source rsp_if
);

   ptts_pkg::state_type state_ff, state_in;
   ptts_pkg::cmd_type   cmd;
   ptts_pkg::fire_type  fire_vec [SLOT_COUNT];
   ptts_pkg::fire_type  sel;
   logic [SLOT_COUNT:0] token;

   logic req_accept;
   logic is_tick;
   logic out_free;
   logic step;
   logic scan_done;

   // Held firing, waiting to learn whether it is the last one.
   logic                           pend_valid_ff, pend_valid_in;
   logic [ptts_pkg::SLOT_W-1:0]    pend_slot_ff, pend_slot_in;
   logic [ptts_pkg::HANDLER_W-1:0] pend_handler_ff, pend_handler_in;

   // Response register.
   logic                           rsp_valid_ff, rsp_valid_in;
   ptts_pkg::kind_type             rsp_kind_ff, rsp_kind_in;
   logic                           rsp_status_ff, rsp_status_in;
   logic [ptts_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [ptts_pkg::HANDLER_W-1:0] rsp_handler_ff, rsp_handler_in;
   logic                           rsp_last_ff, rsp_last_in;

   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign req_accept = req_if.valid && req_if.ready;
   assign is_tick    = (ptts_pkg::op_type'(req_if.op) == ptts_pkg::OP_TICK);

   // Operation broadcast to the cells.
   always_comb begin
      cmd.valid       = req_accept && !is_tick;
      cmd.op          = ptts_pkg::op_type'(req_if.op);
      cmd.slot        = req_if.slot;
      cmd.handler     = req_if.handler;
      cmd.period      = req_if.period;
      cmd.first_delay = req_if.first_delay;
   end

   // Row of slot cells; a tick injects the token into the first cell.
   assign token[0] = req_accept && is_tick;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      ptts_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .token_in  (token[i]),
         .step      (step),
         .token_out (token[i+1]),
         .fire_out  (fire_vec[i])
      );
   end

   // Only the token holder can report a firing, so an OR selects it.
   always_comb begin
      sel = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         sel = ptts_pkg::fire_type'(sel | fire_vec[i]);
      end
   end

   // Hold the scan when a held firing must be sent but the output is full.
   assign step      = !(sel.fire && pend_valid_ff && !out_free);
   assign scan_done = token[SLOT_COUNT] && step;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptts_pkg::ST_IDLE:   if (req_accept && is_tick) state_in = ptts_pkg::ST_SCAN;
         ptts_pkg::ST_SCAN:   if (scan_done) state_in = ptts_pkg::ST_FINISH;
         ptts_pkg::ST_FINISH: if (out_free) state_in = ptts_pkg::ST_IDLE;
         default:             state_in = ptts_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      case (state_ff)
         ptts_pkg::ST_IDLE: req_if.ready = out_free;
         default:           req_if.ready = 1'b0;
      endcase
   end

   // Held firing and response register loading.
   always_comb begin
      pend_valid_in   = pend_valid_ff;
      pend_slot_in    = pend_slot_ff;
      pend_handler_in = pend_handler_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_handler_in  = rsp_handler_ff;
      rsp_last_in     = rsp_last_ff;

      if (cmd.valid) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = ptts_pkg::KIND_STATUS;
         rsp_status_in  = ((cmd.op == ptts_pkg::OP_CREATE) && (cmd.handler == '0)) ?
                          ptts_pkg::STATUS_NO_HANDLER : ptts_pkg::STATUS_OK;
         rsp_slot_in    = '0;
         rsp_handler_in = '0;
         rsp_last_in    = 1'b1;
      end

      if ((state_ff == ptts_pkg::ST_SCAN) && sel.fire && step) begin
         if (pend_valid_ff) begin
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = ptts_pkg::KIND_FIRED;
            rsp_status_in  = ptts_pkg::STATUS_OK;
            rsp_slot_in    = pend_slot_ff;
            rsp_handler_in = pend_handler_ff;
            rsp_last_in    = 1'b0;
         end
         pend_valid_in   = 1'b1;
         pend_slot_in    = sel.slot;
         pend_handler_in = sel.handler;
      end

      if ((state_ff == ptts_pkg::ST_FINISH) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ptts_pkg::STATUS_OK;
         rsp_last_in   = 1'b1;
         if (pend_valid_ff) begin
            rsp_kind_in    = ptts_pkg::KIND_FIRED;
            rsp_slot_in    = pend_slot_ff;
            rsp_handler_in = pend_handler_ff;
         end else begin
            rsp_kind_in    = ptts_pkg::KIND_TICK_NONE;
            rsp_slot_in    = '0;
            rsp_handler_in = '0;
         end
         pend_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptts_pkg::ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_slot_ff    <= pend_slot_in;
      pend_handler_ff <= pend_handler_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_handler_ff  <= rsp_handler_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.kind          = rsp_kind_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.fired_slot    = rsp_slot_ff;
   assign rsp_if.fired_handler = rsp_handler_ff;
   assign rsp_if.last          = rsp_last_ff;

endmodule

// ===== tb/sv/tb_periodic_task_tick_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task tick scheduler testbench
// Feeds create, suspend, resume, delete and tick requests through the request
// channel and predicts every response from a task table kept in the bench.
// A directed opening covers empty ticks, creates without a handler, creates on
// occupied slots, deleted slots that keep counting, unused operation codes and
// a tick that fires every slot. Random traffic with short periods follows.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler;
   import ptts_pkg::*;

   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int SLOTS         = SLOT_COUNT_DEF;
   localparam int RANDOM_ITEMS  = 308;
   localparam int MAX_GAP       = 12;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 4 * (SLOTS + 2);
   localparam int REPORT_LIMIT  = 10;

   // One request as the sender presents it.
   typedef struct {
      logic [OP_W-1:0]      op;
      logic [SLOT_W-1:0]    slot;
      logic [HANDLER_W-1:0] handler;
      logic [TIME_W-1:0]    period;
      logic [TIME_W-1:0]    first_delay;
      logic                 drain_first;
   } sched_request_type;

   // One response as the receiver sees it.
   typedef struct {
      logic [KIND_W-1:0]    kind;
      logic                 status;
      logic [SLOT_W-1:0]    fired_slot;
      logic [HANDLER_W-1:0] fired_handler;
      logic                 last;
   } sched_result_type;

   logic clock;
   logic reset;

   ptts_req_if req_ch();
   ptts_rsp_if rsp_ch();

   periodic_task_tick_scheduler dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   sched_request_type pending_requests[$];
   sched_result_type  awaited_results[$];
   int                open_results;
   int                mismatch_count;
   int                quiet_cycles;

   // Task table as the bench expects it.
   logic [HANDLER_W-1:0] task_handler[SLOTS];
   logic [TIME_W-1:0]    task_period[SLOTS];
   logic [TIME_W-1:0]    task_countdown[SLOTS];
   logic                 task_running[SLOTS];

   always #CLK_HALF clock = ~clock;

   function automatic void add_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                       logic [HANDLER_W-1:0] handler,
                                       logic [TIME_W-1:0] period,
                                       logic [TIME_W-1:0] first_delay, logic drain_first);
      sched_request_type r;
      r = '{op, slot, handler, period, first_delay, drain_first};
      pending_requests.push_back(r);
   endfunction

   // Apply one accepted request to the task table and queue its responses.
   function automatic void advance_task_table(sched_request_type r);
      int               fired;
      logic             status;
      sched_result_type res;
      fired = 0;
      status = STATUS_OK;
      if (r.op == OP_TICK) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (task_running[i]) begin
               if (task_countdown[i] == '0) begin
                  if (task_handler[i] != '0 && fired < SLOTS) begin
                     res = '{KIND_FIRED, STATUS_OK, SLOT_W'(i), task_handler[i], 1'b0};
                     awaited_results.push_back(res);
                     fired++;
                  end
                  task_countdown[i] = task_period[i] - 1'b1;
               end else begin
                  task_countdown[i] = task_countdown[i] - 1'b1;
               end
            end
         end
         if (fired == 0) begin
            res = '{KIND_TICK_NONE, STATUS_OK, '0, '0, 1'b1};
            awaited_results.push_back(res);
         end else begin
            awaited_results[awaited_results.size() - 1].last = 1'b1;
         end
      end else begin
         if (r.op == OP_CREATE) begin
            if (r.handler == '0) begin
               status = STATUS_NO_HANDLER;
            end else if (r.slot < SLOTS && task_handler[r.slot] == '0) begin
               task_handler[r.slot]   = r.handler;
               task_period[r.slot]    = r.period;
               task_countdown[r.slot] = r.first_delay;
               task_running[r.slot]   = 1'b1;
            end
         end else if (r.slot < SLOTS) begin
            if (r.op == OP_SUSPEND) task_running[r.slot] = 1'b0;
            else if (r.op == OP_RESUME) task_running[r.slot] = 1'b1;
            else if (r.op == OP_DELETE) task_handler[r.slot] = '0;
         end
         res = '{KIND_STATUS, status, '0, '0, 1'b1};
         awaited_results.push_back(res);
      end
   endfunction

   function automatic string describe_result(sched_result_type r);
      return $sformatf("kind=%0d status=%0d slot=%0d handler=%0d last=%0d",
                       r.kind, r.status, r.fired_slot, r.fired_handler, r.last);
   endfunction

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin : drive_requests
      logic taken;
      logic offer;
      int   burst_left;
      int   gap_left;
      taken = req_ch.valid && req_ch.ready;
      offer = 1'b0;
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (taken) begin
            void'(pending_requests.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            end
         end
         if (!req_ch.valid || taken) begin
            // A request marked drain_first waits until no response is outstanding.
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() != 0) begin
               offer = !(pending_requests[0].drain_first && (taken || open_results != 0));
            end
            if (offer) begin
               req_ch.op          <= pending_requests[0].op;
               req_ch.slot        <= pending_requests[0].slot;
               req_ch.handler     <= pending_requests[0].handler;
               req_ch.period      <= pending_requests[0].period;
               req_ch.first_delay <= pending_requests[0].first_delay;
            end
            req_ch.valid <= offer;
         end
      end
   end

   // Response receiver: ready follows a rotating pattern that is reloaded now and then.
   always @(posedge clock) begin : drive_ready
      logic [10:0] ready_pattern;
      int          pattern_age;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_pattern = '1;
         pattern_age = 0;
      end else begin
         if (pattern_age == 63) begin
            pattern_age = 0;
            if ($urandom_range(0, 3) == 0) ready_pattern = '1;
            else ready_pattern = 11'($urandom) | 11'd1;
         end else begin
            pattern_age++;
            ready_pattern = {ready_pattern[9:0], ready_pattern[10]};
         end
         rsp_ch.ready <= ready_pattern[10];
      end
   end

   // Monitor: check each accepted response, then predict from each accepted request.
   always @(posedge clock) begin : check_responses
      sched_result_type  got;
      sched_result_type  want;
      sched_request_type seen;
      if (reset) begin
         open_results <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.kind, rsp_ch.status, rsp_ch.fired_slot, rsp_ch.fired_handler,
                    rsp_ch.last};
            if (awaited_results.size() == 0) begin
               note_mismatch({"unexpected response: ", describe_result(got)});
            end else begin
               want = awaited_results.pop_front();
               if (got.kind !== want.kind || got.status !== want.status ||
                   got.fired_slot !== want.fired_slot ||
                   got.fired_handler !== want.fired_handler || got.last !== want.last)
                  note_mismatch({"expected ", describe_result(want), " got ",
                                 describe_result(got)});
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen = '{req_ch.op, req_ch.slot, req_ch.handler, req_ch.period,
                     req_ch.first_delay, 1'b0};
            advance_task_table(seen);
         end
         open_results <= awaited_results.size();
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin : watchdog
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_test
      int                   pick;
      logic [OP_W-1:0]      op;
      logic [HANDLER_W-1:0] handler;
      logic [TIME_W-1:0]    period;
      logic [TIME_W-1:0]    first_delay;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = '0;
      req_ch.slot = '0;
      req_ch.handler = '0;
      req_ch.period = '0;
      req_ch.first_delay = '0;
      rsp_ch.ready = 1'b0;
      mismatch_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
         task_handler[i] = '0;
         task_period[i] = '0;
         task_countdown[i] = '0;
         task_running[i] = 1'b0;
      end

      // Directed opening: empty tick, create corner cases, a full tick and
      // the flag operations, with a deleted slot that keeps counting.
      add_request(OP_TICK, '0, '0, '0, '0, 1'b0);
      add_request(OP_CREATE, '0, '0, 16'd5, 16'd5, 1'b0);
      add_request(OP_CREATE, '0, 8'hFF, 16'd0, 16'd0, 1'b0);
      add_request(OP_CREATE, '0, 8'h01, 16'd3, 16'd3, 1'b0);
      add_request(OP_CREATE, 3'd7, 8'h80, 16'hFFFF, 16'd0, 1'b0);
      for (int s = 1; s <= 6; s++)
         add_request(OP_CREATE, SLOT_W'(s), HANDLER_W'(s * 37), 16'd1, 16'd0, 1'b0);
      add_request(OP_TICK, '0, '0, '0, '0, 1'b0);
      add_request(OP_TICK, '0, '0, '0, '0, 1'b0);
      add_request(OP_SUSPEND, 3'd1, '0, '0, '0, 1'b0);
      add_request(OP_TICK, '0, '0, '0, '0, 1'b0);
      add_request(OP_RESUME, 3'd1, '0, '0, '0, 1'b0);
      add_request(OP_DELETE, 3'd2, '0, '0, '0, 1'b0);
      add_request(OP_TICK, '0, '0, '0, '0, 1'b0);
      add_request(OP_CREATE, 3'd2, 8'h33, 16'd2, 16'hFFFF, 1'b1);
      for (int o = OP_DELETE + 1; o < 2 ** OP_W; o++)
         add_request(OP_W'(o), OP_W'(o), 8'hA5, 16'hFFFF, 16'hFFFF, 1'b0);
      add_request(OP_TICK, '0, '0, '0, '0, 1'b0);

      // Random traffic: mostly ticks and creates with short periods so that
      // slots fire often, with occasional full-range times and drain points.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) op = OP_TICK;
         else if (pick < 67) op = OP_CREATE;
         else if (pick < 77) op = OP_SUSPEND;
         else if (pick < 87) op = OP_RESUME;
         else if (pick < 96) op = OP_DELETE;
         else op = OP_W'($urandom_range(OP_DELETE + 1, 2 ** OP_W - 1));
         handler = ($urandom_range(0, 7) == 0) ? '0 : HANDLER_W'($urandom_range(1, 255));
         period = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(0, 4));
         first_delay = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom)
                                                   : TIME_W'($urandom_range(0, 4));
         add_request(op, SLOT_W'($urandom), handler, period, first_delay,
                     $urandom_range(0, 39) == 0);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for all requests to go out and all responses to come back.
      while (pending_requests.size() != 0 || open_results != 0 || awaited_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ptts_pkg.sv
rtl/core/ptts_if.sv
rtl/core/ptts_cell.sv
rtl/core/periodic_task_tick_scheduler.sv
tb/sv/tb_periodic_task_tick_scheduler.sv
